[rtl/abl565_pkg.sv]
// ----------------------------------------------------------------------------
// abl565_pkg: shared types and functions of the ARGB-over-RGB565 blend unit
// Beat formats, command and register codes, and the per-channel blend.
// ----------------------------------------------------------------------------
package abl565_pkg;

  // Default frame store depth in 16-bit words.
  localparam int unsigned FB_DEPTH_DEFAULT = 131072;

  // Screen positions: column + row * line length of 11-bit values.
  localparam int unsigned PosW  = 23;
  localparam int unsigned AddrW = 17;
  localparam int unsigned CfgW  = 11;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgW-1:0] ORIGIN_X_RST      = 11'd0;
  localparam logic [CfgW-1:0] ORIGIN_Y_RST      = 11'd0;
  localparam logic [CfgW-1:0] BITMAP_WIDTH_RST  = 11'd1;
  localparam logic [CfgW-1:0] BITMAP_HEIGHT_RST = 11'd1;
  localparam logic [CfgW-1:0] SCREEN_WIDTH_RST  = 11'd320;
  localparam logic [CfgW-1:0] SCREEN_HEIGHT_RST = 11'd240;

  typedef enum logic [1:0] {
    CMD_FB_WRITE = 2'd0,
    CMD_FB_READ  = 2'd1,
    CMD_PIXEL    = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_BITMAP_WIDTH  = 3'd2,
    REG_BITMAP_HEIGHT = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [AddrW-1:0] fb_address;
    logic [15:0]      fb_data;
    logic [7:0]       src_alpha;
    logic [7:0]       src_red;
    logic [7:0]       src_green;
    logic [7:0]       src_blue;
  } in_beat_t;

  typedef struct packed {
    logic             kind;
    logic             written;
    logic [AddrW-1:0] out_address;
    logic [15:0]      out_color;
    logic             end_of_bitmap;
  } out_beat_t;

  typedef struct packed {
    logic [CfgW-1:0] origin_x;
    logic [CfgW-1:0] origin_y;
    logic [CfgW-1:0] bitmap_width;
    logic [CfgW-1:0] bitmap_height;
    logic [CfgW-1:0] screen_width;
    logic [CfgW-1:0] screen_height;
  } cfg_t;

  // One resolved frame store access on its way to the memory.
  typedef struct packed {
    logic [1:0]       op;
    logic             hit;
    logic [AddrW-1:0] out_address;
    logic [15:0]      fb_data;
    logic [7:0]       alpha;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last;
  } acc_t;

  // Last counter value of a bitmap dimension; zero acts as one, and the
  // size saturates at 1024.
  function automatic logic [9:0] size_m1(logic [CfgW-1:0] v);
    logic [9:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > 11'd1024) begin
      r = '1;
    end else begin
      r = 10'(v - 11'd1);
    end
    return r;
  endfunction

  function automatic logic [15:0] blend565(logic [15:0] d, logic [7:0] a,
                                           logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b);
    logic [7:0]  na;
    logic [7:0]  dr;
    logic [7:0]  dg;
    logic [7:0]  db;
    logic [16:0] sr;
    logic [16:0] sg;
    logic [16:0] sb;
    na = 8'd255 - a;
    dr = {d[15:11], 3'b000};
    dg = {d[10:5], 2'b00};
    db = {d[4:0], 3'b000};
    sr = ({9'd0, r} * {9'd0, a}) + ({9'd0, na} * {9'd0, dr});
    sg = ({9'd0, g} * {9'd0, a}) + ({9'd0, na} * {9'd0, dg});
    sb = ({9'd0, b} * {9'd0, a}) + ({9'd0, na} * {9'd0, db});
    return {sr[15:11], sg[15:10], sb[15:11]};
  endfunction

endpackage

[rtl/abl565_place.sv]
// ----------------------------------------------------------------------------
// abl565_place: bitmap placement and address stages
// Steps the source column and row counters, places each pixel on screen and
// resolves every beat into a frame store word address over two stages.
// ----------------------------------------------------------------------------
module abl565_place #(
  parameter int unsigned FbDepth = abl565_pkg::FB_DEPTH_DEFAULT,
  localparam int unsigned IdxW = $clog2(FbDepth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 in_valid_i,
  input  abl565_pkg::in_beat_t in_beat_i,
  input  abl565_pkg::cfg_t     cfg_i,
  output logic                 acc_valid_o,
  output abl565_pkg::acc_t     acc_o,
  output logic [IdxW-1:0]      acc_idx_o
);
  import abl565_pkg::*;

  typedef struct packed {
    in_beat_t    beat;
    logic [10:0] x;
    logic [10:0] y;
    logic        on_screen;
    logic        last;
  } s1_t;

  logic [9:0]  col_q, col_d;
  logic [9:0]  row_q, row_d;
  logic        take;
  logic        is_pix;
  logic [11:0] x_pos;
  logic [11:0] y_pos;
  logic        col_end;
  logic        row_end;
  logic        s1_valid_q;
  s1_t         s1_q, s1_d;

  logic [21:0]     row_base;
  logic [PosW-1:0] addr_wide;
  logic            in_store;
  logic            acc_valid_q;
  acc_t            acc_q, acc_d;
  logic [IdxW-1:0] idx_q;

  assign take   = in_valid_i && adv_i;
  assign is_pix = in_beat_i.cmd == CMD_PIXEL;

  // Both sums fit 12 bits, so the top bit is the sign of the screen position.
  assign x_pos   = {cfg_i.origin_x[10], cfg_i.origin_x} + {2'b00, col_q};
  assign y_pos   = {cfg_i.origin_y[10], cfg_i.origin_y} + {2'b00, row_q};
  assign col_end = col_q >= size_m1(cfg_i.bitmap_width);
  assign row_end = row_q >= size_m1(cfg_i.bitmap_height);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take && is_pix) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + 10'd1;
      end else begin
        col_d = col_q + 10'd1;
      end
    end
  end

  always_comb begin
    s1_d.beat      = in_beat_i;
    s1_d.x         = x_pos[10:0];
    s1_d.y         = y_pos[10:0];
    s1_d.on_screen = !x_pos[11] && !y_pos[11] &&
                     (x_pos[10:0] < cfg_i.screen_width) &&
                     (y_pos[10:0] < cfg_i.screen_height);
    s1_d.last      = is_pix && col_end && row_end;
  end

  assign row_base = {11'd0, s1_q.y} * {11'd0, cfg_i.screen_width};

  always_comb begin
    if (s1_q.beat.cmd == CMD_PIXEL) begin
      addr_wide = {1'b0, row_base} + {12'd0, s1_q.x};
    end else begin
      addr_wide = {(PosW-AddrW)'(0), s1_q.beat.fb_address};
    end
    in_store = addr_wide < PosW'(FbDepth);

    acc_d.op          = s1_q.beat.cmd;
    acc_d.hit         = (s1_q.beat.cmd == CMD_PIXEL) ? (s1_q.on_screen && in_store)
                                                     : in_store;
    acc_d.out_address = addr_wide[AddrW-1:0];
    acc_d.fb_data     = s1_q.beat.fb_data;
    acc_d.alpha       = s1_q.beat.src_alpha;
    acc_d.red         = s1_q.beat.src_red;
    acc_d.green       = s1_q.beat.src_green;
    acc_d.blue        = s1_q.beat.src_blue;
    acc_d.last        = s1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      acc_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (adv_i) begin
        s1_valid_q  <= in_valid_i;
        acc_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q  <= s1_d;
      acc_q <= acc_d;
      idx_q <= addr_wide[IdxW-1:0];
    end
  end

  assign acc_valid_o = acc_valid_q;
  assign acc_o       = acc_q;
  assign acc_idx_o   = idx_q;

`ifndef NO_ASSERTIONS
  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(col_q) && $stable(row_q))
    else $error("source counters moved while the pipeline was held");

  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.last |-> s1_q.beat.cmd == CMD_PIXEL)
    else $error("end of bitmap flagged on a host access");
`endif

endmodule

[rtl/abl565_fbuf.sv]
// ----------------------------------------------------------------------------
// abl565_fbuf: frame store with read-modify-write blend stage
// Reads the addressed word, blends or replaces it in the blend stage and writes
// it back, forwarding the word just written to a read of the same entry.
// ----------------------------------------------------------------------------
module abl565_fbuf #(
  parameter int unsigned FbDepth = abl565_pkg::FB_DEPTH_DEFAULT,
  localparam int unsigned IdxW = $clog2(FbDepth)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  acc_valid_i,
  input  abl565_pkg::acc_t      acc_i,
  input  logic [IdxW-1:0]       acc_idx_i,
  output logic                  res_valid_o,
  output abl565_pkg::out_beat_t res_o
);
  import abl565_pkg::*;

  logic [15:0]     store_mem [FbDepth];
  logic [15:0]     rd_q;
  logic            s3_valid_q;
  acc_t            s3_q;
  logic [IdxW-1:0] s3_idx_q;
  logic            fwd_q;
  logic [15:0]     fwd_word_q;
  logic [15:0]     old_word;
  logic [15:0]     new_word;
  logic            wr_en;

  assign old_word = fwd_q ? fwd_word_q : rd_q;
  assign new_word = (s3_q.op == CMD_PIXEL)
                    ? blend565(old_word, s3_q.alpha, s3_q.red, s3_q.green, s3_q.blue)
                    : s3_q.fb_data;
  assign wr_en    = s3_valid_q && s3_q.hit &&
                    ((s3_q.op == CMD_PIXEL) || (s3_q.op == CMD_FB_WRITE));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rd_q <= store_mem[acc_idx_i];
      if (wr_en) begin
        store_mem[s3_idx_q] <= new_word;
      end
    end
  end

  // The write of the word in the blend stage lands at the same edge as the
  // read of the next access, so that read sees the old word unless forwarded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (adv_i) begin
      s3_valid_q <= acc_valid_i;
      fwd_q      <= wr_en && (s3_idx_q == acc_idx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_q       <= acc_i;
      s3_idx_q   <= acc_idx_i;
      fwd_word_q <= new_word;
    end
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (s3_q.op)
      CMD_FB_READ: begin
        res_valid_o       = s3_valid_q;
        res_o.out_address = s3_q.out_address;
        res_o.out_color   = s3_q.hit ? old_word : 16'd0;
      end
      CMD_PIXEL: begin
        res_valid_o         = s3_valid_q;
        res_o.kind          = 1'b1;
        res_o.written       = s3_q.hit;
        res_o.out_address   = s3_q.hit ? s3_q.out_address : '0;
        res_o.out_color     = s3_q.hit ? new_word : 16'd0;
        res_o.end_of_bitmap = s3_q.last;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(s3_valid_q) && $stable(s3_idx_q) && $stable(fwd_q))
    else $error("blend stage changed while the pipeline was held");

  a_fwd_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !wr_en |=> !fwd_q)
    else $error("forwarding selected without a preceding write");

  a_written_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.written |-> res_o.kind && wr_en)
    else $error("written flag set on a beat that did not update the store");
`endif

endmodule

[rtl/argb_bitmap_blend_onto_rgb565_unit.sv]
// ----------------------------------------------------------------------------
// argb_bitmap_blend_onto_rgb565_unit: ARGB8888 over RGB565 blend unit
// Keeps an RGB565 frame store, serves host word writes and reads, and blends
// a raster stream of source pixels onto it at a programmable origin.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------
//   in       | sink      | in_valid_i / in_stall_o   | in_beat_i (in_beat_t)
//   out      | source    | out_valid_o / out_stall_i | out_beat_o (out_beat_t)
//   cfg      | sink      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One beat is taken every cycle while the pipeline is not held; its result
// passes the placement, address and blend stages and the output register.
// The rate is set by the frame store: one read port and one write port carry
// one read-modify-write per cycle, with the written word forwarded to a read
// of the same entry. When a result waits on a stalled output, the whole
// pipeline holds and in_stall_o is raised. Reset clears the counters and
// pipeline valids and loads the register defaults; the frame store holds no defined data until written.
module argb_bitmap_blend_onto_rgb565_unit #(
  parameter int unsigned FbDepth = abl565_pkg::FB_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  abl565_pkg::in_beat_t                in_beat_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output abl565_pkg::out_beat_t               out_beat_o,
  input  logic                                cfg_we_i,
  input  logic [abl565_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [abl565_pkg::CfgW-1:0]         cfg_data_i
);
  import abl565_pkg::*;

  localparam int unsigned IdxW = $clog2(FbDepth);

  cfg_t            cfg_q, cfg_d;
  logic            adv;
  logic            acc_valid;
  acc_t            acc;
  logic [IdxW-1:0] acc_idx;
  logic            res_valid;
  out_beat_t       res;
  logic            out_valid_q;
  out_beat_t       out_beat_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_X:      cfg_d.origin_x      = cfg_data_i;
        REG_ORIGIN_Y:      cfg_d.origin_y      = cfg_data_i;
        REG_BITMAP_WIDTH:  cfg_d.bitmap_width  = cfg_data_i;
        REG_BITMAP_HEIGHT: cfg_d.bitmap_height = cfg_data_i;
        REG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_data_i;
        REG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= ORIGIN_X_RST;
      cfg_q.origin_y      <= ORIGIN_Y_RST;
      cfg_q.bitmap_width  <= BITMAP_WIDTH_RST;
      cfg_q.bitmap_height <= BITMAP_HEIGHT_RST;
      cfg_q.screen_width  <= SCREEN_WIDTH_RST;
      cfg_q.screen_height <= SCREEN_HEIGHT_RST;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (adv) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_beat_q <= res;
    end
  end

  abl565_place #(
    .FbDepth(FbDepth)
  ) u_place (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_beat_i),
    .cfg_i      (cfg_q),
    .acc_valid_o(acc_valid),
    .acc_o      (acc),
    .acc_idx_o  (acc_idx)
  );

  abl565_fbuf #(
    .FbDepth(FbDepth)
  ) u_fbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .acc_valid_i(acc_valid),
    .acc_i      (acc),
    .acc_idx_i  (acc_idx),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

[tb/abl565_blend_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// abl565_blend_checker: result predictor and comparator for the blend unit
// Watches the input, output and register ports of the unit. It keeps its own
// copy of the frame store, the raster counters and the register settings,
// and checks every output beat, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module abl565_blend_checker #(
  parameter int unsigned FbDepth = abl565_pkg::FB_DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  abl565_pkg::in_beat_t               in_beat_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  abl565_pkg::out_beat_t              out_beat_i,
  input  logic                               cfg_we_i,
  input  logic [abl565_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [abl565_pkg::CfgW-1:0]        cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);
  import abl565_pkg::*;

  localparam logic [15:0] RedMask   = 16'hF800;
  localparam logic [15:0] GreenMask = 16'h07E0;
  localparam logic [15:0] BlueMask  = 16'h001F;

  bit [15:0]   frame_copy [FbDepth];
  cfg_t        view;
  int unsigned column;
  int unsigned row;
  out_beat_t   pending_results [$];

  // A bitmap dimension of zero counts as one; anything above 1024 saturates.
  function automatic int unsigned bitmap_size(logic [CfgW-1:0] v);
    if (v == '0) return 1;
    if (v > 11'd1024) return 1024;
    return int'(v);
  endfunction

  function automatic logic [15:0] blend_over(logic [15:0] d, in_beat_t b);
    int unsigned a;
    int unsigned na;
    int unsigned dr;
    int unsigned dg;
    int unsigned db;
    int unsigned red;
    int unsigned green;
    int unsigned blue;
    a     = b.src_alpha;
    na    = 255 - a;
    dr    = (d & RedMask) >> 8;
    dg    = (d & GreenMask) >> 3;
    db    = (d & BlueMask) << 3;
    red   = (b.src_red * a + na * dr) >> 11;
    green = (b.src_green * a + na * dg) >> 10;
    blue  = (b.src_blue * a + na * db) >> 11;
    return {red[4:0], green[5:0], blue[4:0]};
  endfunction

  task automatic predict_pixel(input in_beat_t b, output out_beat_t res);
    int x;
    int y;
    int sw;
    int sh;
    int p;
    bit col_end;
    bit row_end;
    res      = '0;
    res.kind = 1'b1;
    sw       = int'(view.screen_width);
    sh       = int'(view.screen_height);
    x        = int'($signed(view.origin_x)) + int'(column);
    y        = int'($signed(view.origin_y)) + int'(row);
    col_end  = column >= bitmap_size(view.bitmap_width) - 1;
    row_end  = row >= bitmap_size(view.bitmap_height) - 1;
    p        = x + y * sw;
    if (x >= 0 && y >= 0 && x < sw && y < sh && p < int'(FbDepth)) begin
      res.written     = 1'b1;
      res.out_address = p[AddrW-1:0];
      res.out_color   = blend_over(frame_copy[p], b);
      frame_copy[p]   = res.out_color;
    end
    if (col_end) begin
      column = 0;
      row    = row_end ? 0 : ((row + 1) & 32'h3FF);
    end else begin
      column = (column + 1) & 32'h3FF;
    end
    res.end_of_bitmap = col_end && row_end;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    out_beat_t got;
    if (!rst_ni) begin
      view.origin_x      = ORIGIN_X_RST;
      view.origin_y      = ORIGIN_Y_RST;
      view.bitmap_width  = BITMAP_WIDTH_RST;
      view.bitmap_height = BITMAP_HEIGHT_RST;
      view.screen_width  = SCREEN_WIDTH_RST;
      view.screen_height = SCREEN_HEIGHT_RST;
      column             = 0;
      row                = 0;
      fail_count_o       = 0;
      checked_o          = 0;
      pending_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ORIGIN_X:      view.origin_x = cfg_data_i;
          REG_ORIGIN_Y:      view.origin_y = cfg_data_i;
          REG_BITMAP_WIDTH:  view.bitmap_width = cfg_data_i;
          REG_BITMAP_HEIGHT: view.bitmap_height = cfg_data_i;
          REG_SCREEN_WIDTH:  view.screen_width = cfg_data_i;
          REG_SCREEN_HEIGHT: view.screen_height = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        case (in_beat_i.cmd)
          CMD_FB_WRITE: begin
            if (in_beat_i.fb_address < FbDepth) begin
              frame_copy[in_beat_i.fb_address] = in_beat_i.fb_data;
            end
          end
          CMD_FB_READ: begin
            want             = '0;
            want.out_address = in_beat_i.fb_address;
            if (in_beat_i.fb_address < FbDepth) begin
              want.out_color = frame_copy[in_beat_i.fb_address];
            end
            pending_results.push_back(want);
          end
          CMD_PIXEL: begin
            predict_pixel(in_beat_i, want);
            pending_results.push_back(want);
          end
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        got = out_beat_i;
        if (pending_results.size() == 0) begin
          $error("output beat with no result pending: %p", got);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          checked_o++;
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fail_count_o++;
          end
          if (got.written !== want.written) begin
            $error("written: expected %0d, got %0d", want.written, got.written);
            fail_count_o++;
          end
          if (got.out_address !== want.out_address) begin
            $error("out_address: expected 0x%05h, got 0x%05h", want.out_address,
                   got.out_address);
            fail_count_o++;
          end
          if (got.out_color !== want.out_color) begin
            $error("out_color: expected 0x%04h, got 0x%04h", want.out_color, got.out_color);
            fail_count_o++;
          end
          if (got.end_of_bitmap !== want.end_of_bitmap) begin
            $error("end_of_bitmap: expected %0d, got %0d", want.end_of_bitmap,
                   got.end_of_bitmap);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = pending_results.size();
  end

endmodule

[tb/tb_argb_bitmap_blend_onto_rgb565_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_argb_bitmap_blend_onto_rgb565_unit: stimulus and verdict for the blend unit
// Drives host frame store writes and reads, raster streams of source pixels
// and a series of origin, bitmap and screen settings under several idle
// patterns. A checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_argb_bitmap_blend_onto_rgb565_unit;
  import abl565_pkg::*;

  localparam int unsigned FbDepth       = FB_DEPTH_DEFAULT;
  localparam int          CycleLimit    = 400000;
  localparam int          DrainCycles   = 12;
  localparam int          HoldCycles    = 300;
  localparam int          MaxGap        = 16;
  localparam int          BeatsPerPhase = 95;
  localparam int          NumViews      = 10;
  localparam logic [1:0]  CmdUnused     = 2'd3;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_beat_t           in_beat   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_beat_t          out_beat;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data  = '0;

  int fail_count;
  int pending;
  int checked;

  // Stimulus-side bookkeeping: which store entries hold data, and where the
  // next source pixel will land.
  bit          fb_init [FbDepth];
  int unsigned written_q [$];
  cfg_t        cur_view;
  int unsigned trk_col;
  int unsigned trk_row;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit rx_hold_req    = 1'b0;
  int cycle_count    = 0;

  int n_pixels = 0;
  int n_reads  = 0;
  int n_writes = 0;
  int n_unused = 0;

  argb_bitmap_blend_onto_rgb565_unit #(
    .FbDepth(FbDepth)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  abl565_blend_checker #(
    .FbDepth(FbDepth)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cfg_t make_view(int ox, int oy, int bw, int bh, int sw, int sh);
    cfg_t v;
    v.origin_x      = 11'(ox);
    v.origin_y      = 11'(oy);
    v.bitmap_width  = 11'(bw);
    v.bitmap_height = 11'(bh);
    v.screen_width  = 11'(sw);
    v.screen_height = 11'(sh);
    return v;
  endfunction

  function automatic int unsigned eff_size(logic [CfgW-1:0] v);
    if (v == '0) return 1;
    if (v > 11'd1024) return 1024;
    return int'(v);
  endfunction

  // Every field gets random content; the caller overrides what matters.
  function automatic in_beat_t random_beat(logic [1:0] c);
    in_beat_t b;
    b.cmd        = c;
    b.fb_address = AddrW'($urandom());
    b.fb_data    = 16'($urandom());
    b.src_alpha  = 8'($urandom());
    b.src_red    = 8'($urandom());
    b.src_green  = 8'($urandom());
    b.src_blue   = 8'($urandom());
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = 0;
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    while (gap < MaxGap && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic fb_write(input int unsigned addr, input logic [15:0] data);
    in_beat_t b;
    b            = random_beat(CMD_FB_WRITE);
    b.fb_address = addr[AddrW-1:0];
    b.fb_data    = data;
    if (!fb_init[addr]) begin
      fb_init[addr] = 1'b1;
      written_q.push_back(addr);
    end
    n_writes++;
    send_beat(b);
  endtask

  task automatic fb_read(input int unsigned addr);
    in_beat_t b;
    b            = random_beat(CMD_FB_READ);
    b.fb_address = addr[AddrW-1:0];
    n_reads++;
    send_beat(b);
  endtask

  task automatic read_any();
    fb_read(written_q[$urandom_range(0, written_q.size() - 1)]);
  endtask

  task automatic send_unused();
    n_unused++;
    send_beat(random_beat(CmdUnused));
  endtask

  // A pixel that will land on a store entry holding no data yet is preceded
  // by a write of that entry.
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] bl);
    in_beat_t b;
    int x;
    int y;
    int sw;
    int sh;
    int p;
    sw = int'(cur_view.screen_width);
    sh = int'(cur_view.screen_height);
    x  = int'($signed(cur_view.origin_x)) + int'(trk_col);
    y  = int'($signed(cur_view.origin_y)) + int'(trk_row);
    p  = x + y * sw;
    if (x >= 0 && y >= 0 && x < sw && y < sh && p < int'(FbDepth) && !fb_init[p]) begin
      fb_write(p, 16'($urandom()));
    end
    if (trk_col >= eff_size(cur_view.bitmap_width) - 1) begin
      trk_col = 0;
      trk_row = (trk_row >= eff_size(cur_view.bitmap_height) - 1) ? 0 : trk_row + 1;
    end else begin
      trk_col++;
    end
    b           = random_beat(CMD_PIXEL);
    b.src_alpha = a;
    b.src_red   = r;
    b.src_green = g;
    b.src_blue  = bl;
    n_pixels++;
    send_beat(b);
  endtask

  // Wait until every result is out, then give trailing writes time to land.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_view(input cfg_t v);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= v.origin_x;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data  <= v.origin_y;
    @(posedge clk);
    cfg_index <= REG_BITMAP_WIDTH;
    cfg_data  <= v.bitmap_width;
    @(posedge clk);
    cfg_index <= REG_BITMAP_HEIGHT;
    cfg_data  <= v.bitmap_height;
    @(posedge clk);
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= v.screen_width;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= v.screen_height;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_view = v;
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    cfg_t       views [NumViews];
    int         k;
    int         pick;
    logic [7:0] alpha;

    views[0] = make_view(0, 0, 4, 3, 320, 240);
    views[1] = make_view(-2, -1, 5, 4, 320, 240);
    views[2] = make_view(317, 237, 6, 5, 320, 240);
    // Rows past 127 on a 1024-wide screen fall beyond the store.
    views[3] = make_view(1020, 126, 6, 4, 1024, 1024);
    views[4] = make_view(0, 0, 1, 1, 1, 1);
    views[5] = make_view(-1024, -1024, 1024, 1024, 1024, 1024);
    // Bitmap sizes of zero and above 1024 are clamped by the unit.
    views[6] = make_view(1023, 1023, 0, 2047, 1024, 1024);
    views[7] = make_view(7, 3, 8, 2, 40, 30);
    views[8] = make_view(-3, 20, 7, 16, 25, 24);
    views[9] = make_view(100, 50, 2, 9, 1024, 100);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_view = make_view(0, 0, 1, 1, 320, 240);
    trk_col  = 0;
    trk_row  = 0;

    // Directed part: address and data extremes, every command, and blends at
    // alpha extremes onto a single-pixel bitmap.
    fb_write(0, 16'hFFFF);
    fb_write(FbDepth - 1, 16'h0000);
    fb_write(32'h15555, 16'hAAAA);
    fb_write(32'h0AAAA, 16'h5555);
    fb_read(0);
    fb_read(FbDepth - 1);
    fb_read(32'h15555);
    fb_read(32'h0AAAA);
    send_unused();
    send_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd255, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd255, 8'h00, 8'h00, 8'h00);
    send_pixel(8'd128, 8'h55, 8'hAA, 8'h0F);
    send_pixel(8'd1, 8'hFF, 8'h00, 8'hFF);
    fb_read(0);
    // A bitmap that starts off screen at the top-left corner.
    program_view(make_view(-1, -1, 3, 3, 320, 240));
    repeat (9) send_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
    fb_read(0);

    for (k = 0; k < NumViews; k++) begin
      program_view(views[k]);
      case (k % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
        default: begin src_idle_pct = 32; sink_stall_pct = 32; end
      endcase
      // The output holds off while the input keeps offering beats.
      if (k == 4) rx_hold_req = 1'b1;
      repeat (BeatsPerPhase) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          case ($urandom_range(0, 7))
            0:       alpha = 8'd0;
            1:       alpha = 8'd255;
            default: alpha = 8'($urandom());
          endcase
          send_pixel(alpha, 8'($urandom()), 8'($urandom()), 8'($urandom()));
        end else if (pick < 78) begin
          read_any();
        end else if (pick < 95) begin
          fb_write((pick < 88) ? written_q[$urandom_range(0, written_q.size() - 1)]
                               : $urandom_range(0, FbDepth - 1), 16'($urandom()));
        end else begin
          send_unused();
        end
      end
    end
    drain();

    $display("Sent %0d pixels, %0d reads, %0d writes and %0d unused beats over %0d settings.",
             n_pixels, n_reads, n_writes, n_unused, NumViews + 2);
    $display("Checked %0d output beats under four idle patterns and one long output hold.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
